@@ rtl/ltc_pkg.sv @@
`timescale 1ns / 1ps

package ltc_pkg;

  // Item action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Register select codes
  localparam logic [1:0] REG_CONTROL = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_LINE    = 2'd2;
  localparam logic [1:0] REG_COMPARE = 2'd3;

  // Status mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Register reset values
  localparam logic [7:0] CONTROL_RESET = 8'h91;
  localparam logic [7:0] STATUS_RESET  = 8'h85;

  // Line numbers
  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE   = 8'd153;

  localparam int CLOCK_W = 9;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tick_clocks;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       stat_irq;
    logic       vblank_irq;
    logic       hblank_entered;
    logic       line_done;
    logic [7:0] line_number;
  } result_t;

endpackage

@@ rtl/ltc_in_reg.sv @@
`timescale 1ns / 1ps

module ltc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  ltc_pkg::item_t in_item,
  input  logic          advance,
  output logic          in_stall,
  output logic          item_valid,
  output ltc_pkg::item_t item
);
  import ltc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Hold the word while the core cannot advance it
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/ltc_core.sv @@
`timescale 1ns / 1ps

module ltc_core #(
  parameter int LINE_CLOCKS = 456,
  parameter int OAM_CLOCKS  = 80,
  parameter int XFER_CLOCKS = 172
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ltc_pkg::item_t   item,
  output ltc_pkg::result_t res
);
  import ltc_pkg::*;

  localparam int OAM_START  = (LINE_CLOCKS > OAM_CLOCKS) ? LINE_CLOCKS - OAM_CLOCKS : 0;
  localparam int XFER_START = (OAM_START > XFER_CLOCKS) ? OAM_START - XFER_CLOCKS : 0;
  localparam logic [CLOCK_W:0] LINE_END_C   = (CLOCK_W + 1)'(LINE_CLOCKS);
  localparam logic [CLOCK_W:0] OAM_START_C  = (CLOCK_W + 1)'(OAM_START);
  localparam logic [CLOCK_W:0] XFER_START_C = (CLOCK_W + 1)'(XFER_START);

  logic [7:0]         control_r, control_nxt;
  logic [7:0]         status_r, status_nxt;
  logic [7:0]         line_r, line_nxt;
  logic [7:0]         compare_r, compare_nxt;
  logic [CLOCK_W-1:0] clock_r, clock_nxt;

  logic [1:0]         mode;
  logic               want;
  logic [7:0]         st;
  logic [CLOCK_W:0]   clk_sum;
  logic [CLOCK_W:0]   clk_wrap;

  // Mode from the clock count as it stands before the tick
  always_comb begin
    priority if (line_r >= VBLANK_LINE) begin
      mode = MODE_VBLANK;
    end else if ({1'b0, clock_r} >= OAM_START_C) begin
      mode = MODE_OAM;
    end else if ({1'b0, clock_r} >= XFER_START_C) begin
      mode = MODE_XFER;
    end else begin
      mode = MODE_HBLANK;
    end
  end

  assign clk_sum  = {1'b0, clock_r} + {{(CLOCK_W - 7){1'b0}}, item.tick_clocks};
  assign clk_wrap = clk_sum - LINE_END_C;

  // Work out next register state and the result word
  always_comb begin
    control_nxt = control_r;
    status_nxt  = status_r;
    line_nxt    = line_r;
    compare_nxt = compare_r;
    clock_nxt   = clock_r;
    res         = '0;
    want        = 1'b0;
    st          = status_r;

    unique case (item.action)
      ACT_READ: begin
        unique case (item.reg_select)
          REG_CONTROL: res.read_data = control_r;
          REG_STATUS:  res.read_data = status_r;
          REG_LINE:    res.read_data = line_r;
          REG_COMPARE: res.read_data = compare_r;
          default:     res.read_data = compare_r;
        endcase
      end
      ACT_WRITE: begin
        unique case (item.reg_select)
          REG_CONTROL: control_nxt = item.write_data;
          // mode and coincidence bits are read-only
          REG_STATUS:  status_nxt  = {item.write_data[7:3], status_r[2:0]};
          REG_LINE:    line_nxt    = item.write_data;
          REG_COMPARE: compare_nxt = item.write_data;
          default:     compare_nxt = item.write_data;
        endcase
      end
      ACT_TICK: begin
        if (!control_r[7]) begin
          // LCD off: park in vblank at the top of the frame
          clock_nxt  = '0;
          line_nxt   = '0;
          status_nxt = {status_r[7:2], MODE_VBLANK};
        end else begin
          st = {status_r[7:2], mode};
          unique case (mode)
            MODE_HBLANK: begin
              want               = st[3];
              res.hblank_entered = (status_r[1:0] != MODE_HBLANK);
            end
            MODE_VBLANK: want = st[4];
            MODE_OAM:    want = st[5];
            default:     want = 1'b0;
          endcase
          res.stat_irq = want && (mode != status_r[1:0]);
          if (line_r == compare_r) begin
            st[2] = 1'b1;
            if (st[6]) begin
              res.stat_irq = 1'b1;
            end
          end else begin
            st[2] = 1'b0;
          end
          status_nxt = st;

          // Advance the clock, at most one line end per tick
          if (clk_sum >= LINE_END_C) begin
            clock_nxt      = clk_wrap[CLOCK_W-1:0];
            res.vblank_irq = (line_r == VBLANK_LINE);
            if (line_r < VBLANK_LINE) begin
              res.line_done   = 1'b1;
              res.line_number = line_r;
            end
            line_nxt = (line_r >= LAST_LINE) ? 8'd0 : line_r + 8'd1;
          end else begin
            clock_nxt = clk_sum[CLOCK_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= CONTROL_RESET;
      status_r  <= STATUS_RESET;
      line_r    <= '0;
      compare_r <= '0;
      clock_r   <= '0;
    end else if (fire) begin
      control_r <= control_nxt;
      status_r  <= status_nxt;
      line_r    <= line_nxt;
      compare_r <= compare_nxt;
      clock_r   <= clock_nxt;
    end
  end

endmodule

@@ rtl/ltc_out_reg.sv @@
`timescale 1ns / 1ps

module ltc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ltc_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output ltc_pkg::result_t out_res
);
  import ltc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // Set on load, drop once the word is taken
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/lcd_line_timing_controller_top.sv @@
`timescale 1ns / 1ps

// LCD line timing controller: each input word is a clock tick carrying a
// count of elapsed clocks, or a read or write of the control, status, line or
// line compare register, and each one gives exactly one result word. The
// block takes one word per cycle while the output side is not stalled: a word
// is held in the input register until the output register can take its result,
// then is applied to the register state and lands in the output register at
// that same edge, from where its result is offered until it is taken. A new word
// can follow every cycle as long as the output side keeps taking words.
// The input stalls only when the output register is full and stalled.
module lcd_line_timing_controller_top #(
  parameter int LINE_CLOCKS = 456,
  parameter int OAM_CLOCKS  = 80,
  parameter int XFER_CLOCKS = 172
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_tick_clocks,
  input  logic [1:0] in_reg_select,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_stat_irq,
  output logic       out_vblank_irq,
  output logic       out_hblank_entered,
  output logic       out_line_done,
  output logic [7:0] out_line_number
);
  import ltc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  assign in_item = '{action: in_action, tick_clocks: in_tick_clocks,
                     reg_select: in_reg_select, write_data: in_write_data};

  // Move the held word into the core when the output register frees up
  assign advance = item_valid && (!out_valid || !out_stall);

  ltc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  ltc_core #(
    .LINE_CLOCKS (LINE_CLOCKS),
    .OAM_CLOCKS  (OAM_CLOCKS),
    .XFER_CLOCKS (XFER_CLOCKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item),
    .res   (res)
  );

  ltc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_read_data      = out_res.read_data;
  assign out_stat_irq       = out_res.stat_irq;
  assign out_vblank_irq     = out_res.vblank_irq;
  assign out_hblank_entered = out_res.hblank_entered;
  assign out_line_done      = out_res.line_done;
  assign out_line_number    = out_res.line_number;

  // Input stalls only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output word");

  // Draw strobe only for visible lines
  a_draw_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_done) |-> (out_line_number < VBLANK_LINE))
    else $error("draw strobe for a line outside the visible range");

  // A line end never raises both a draw strobe and the vblank request
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_line_done && out_vblank_irq))
    else $error("draw strobe and vblank request on the same tick");

  // Read data comes only from reads, which never raise tick flags
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_data != 8'd0)) |->
      !(out_stat_irq || out_vblank_irq || out_hblank_entered || out_line_done))
    else $error("tick flags set alongside read data");

endmodule

@@ bench/lcd_line_timing_controller_top_tb.sv @@
`timescale 1ns / 1ps

module lcd_line_timing_controller_top_tb;
  import ltc_pkg::*;

  localparam int LINE_CLOCKS = 456;
  localparam int OAM_CLOCKS  = 80;
  localparam int XFER_CLOCKS = 172;
  localparam int OAM_START   = (LINE_CLOCKS > OAM_CLOCKS) ? LINE_CLOCKS - OAM_CLOCKS : 0;
  localparam int XFER_START  = (OAM_START > XFER_CLOCKS) ? OAM_START - XFER_CLOCKS : 0;

  // Action code that the block leaves unused
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Status and control register bit positions
  localparam int STAT_COIN      = 2;
  localparam int STAT_HBLANK_IE = 3;
  localparam int STAT_VBLANK_IE = 4;
  localparam int STAT_OAM_IE    = 5;
  localparam int STAT_COIN_IE   = 6;
  localparam int CTRL_ENABLE    = 7;

  localparam int DRAIN_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = ACT_TICK;
  logic [7:0] in_tick_clocks = '0;
  logic [1:0] in_reg_select = REG_CONTROL;
  logic [7:0] in_write_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_stat_irq;
  logic       out_vblank_irq;
  logic       out_hblank_entered;
  logic       out_line_done;
  logic [7:0] out_line_number;

  lcd_line_timing_controller_top #(
    .LINE_CLOCKS(LINE_CLOCKS),
    .OAM_CLOCKS (OAM_CLOCKS),
    .XFER_CLOCKS(XFER_CLOCKS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_tick_clocks    (in_tick_clocks),
    .in_reg_select     (in_reg_select),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_stat_irq      (out_stat_irq),
    .out_vblank_irq    (out_vblank_irq),
    .out_hblank_entered(out_hblank_entered),
    .out_line_done     (out_line_done),
    .out_line_number   (out_line_number)
  );

  // Shadow copy of the timing state
  logic [7:0]        shadow_control;
  logic [7:0]        shadow_status;
  logic [7:0]        shadow_line;
  logic [7:0]        shadow_compare;
  logic [CLOCK_W-1:0] shadow_clock;

  result_t lcd_results_due[$];

  int  error_count = 0;
  bit  idle_on = 1'b1;
  int  hold_request = 0;
  int  ticks_sent = 0;
  int  reads_sent = 0;
  int  writes_sent = 0;
  int  unused_sent = 0;
  int  lines_drawn = 0;
  int  vblanks_seen = 0;
  int  wraps_seen = 0;
  int  input_stall_cycles = 0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Predict one word and advance the shadow state
  task automatic predict_lcd_word(input item_t w, output result_t r);
    logic [1:0] mode;
    logic [1:0] prev;
    logic       want;
    logic [7:0] st;
    int         sum;
    r = '0;
    case (w.action)
      ACT_READ: begin
        case (w.reg_select)
          REG_CONTROL: r.read_data = shadow_control;
          REG_STATUS:  r.read_data = shadow_status;
          REG_LINE:    r.read_data = shadow_line;
          default:     r.read_data = shadow_compare;
        endcase
      end
      ACT_WRITE: begin
        case (w.reg_select)
          REG_CONTROL: shadow_control = w.write_data;
          REG_STATUS:  shadow_status = {w.write_data[7:3], shadow_status[2:0]};
          REG_LINE:    shadow_line = w.write_data;
          default:     shadow_compare = w.write_data;
        endcase
      end
      ACT_TICK: begin
        if (!shadow_control[CTRL_ENABLE]) begin
          shadow_clock = '0;
          shadow_line = '0;
          shadow_status = {shadow_status[7:2], MODE_VBLANK};
        end else begin
          prev = shadow_status[1:0];
          want = 1'b0;
          if (shadow_line >= VBLANK_LINE) mode = MODE_VBLANK;
          else if (int'(shadow_clock) >= OAM_START) mode = MODE_OAM;
          else if (int'(shadow_clock) >= XFER_START) mode = MODE_XFER;
          else mode = MODE_HBLANK;
          st = {shadow_status[7:2], mode};
          case (mode)
            MODE_HBLANK: begin
              want = st[STAT_HBLANK_IE];
              r.hblank_entered = (prev != MODE_HBLANK);
            end
            MODE_VBLANK: want = st[STAT_VBLANK_IE];
            MODE_OAM:    want = st[STAT_OAM_IE];
            default:     want = 1'b0;
          endcase
          if (want && mode != prev) r.stat_irq = 1'b1;
          if (shadow_line == shadow_compare) begin
            st[STAT_COIN] = 1'b1;
            if (st[STAT_COIN_IE]) r.stat_irq = 1'b1;
          end else begin
            st[STAT_COIN] = 1'b0;
          end
          shadow_status = st;
          // Advance the line clock, at most one line end per tick
          sum = int'(shadow_clock) + int'(w.tick_clocks);
          if (sum >= LINE_CLOCKS) begin
            sum -= LINE_CLOCKS;
            if (shadow_line == VBLANK_LINE) r.vblank_irq = 1'b1;
            if (shadow_line < VBLANK_LINE) begin
              r.line_done = 1'b1;
              r.line_number = shadow_line;
            end
            shadow_line = (shadow_line >= LAST_LINE) ? 8'd0 : shadow_line + 8'd1;
          end
          shadow_clock = sum[CLOCK_W-1:0];
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word, wait for acceptance, queue its expected result
  task automatic send_word(input item_t w);
    int      gap;
    result_t r;
    logic [7:0] line_before;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= w.action;
    in_tick_clocks <= w.tick_clocks;
    in_reg_select  <= w.reg_select;
    in_write_data  <= w.write_data;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    line_before = shadow_line;
    predict_lcd_word(w, r);
    lcd_results_due.push_back(r);
    case (w.action)
      ACT_TICK:  ticks_sent++;
      ACT_READ:  reads_sent++;
      ACT_WRITE: writes_sent++;
      default:   unused_sent++;
    endcase
    if (r.line_done) lines_drawn++;
    if (r.vblank_irq) vblanks_seen++;
    if (w.action == ACT_TICK && line_before >= LAST_LINE && shadow_line == 8'd0) wraps_seen++;
  endtask

  function automatic item_t make_word(logic [1:0] act, logic [7:0] ticks,
                                      logic [1:0] sel, logic [7:0] data);
    item_t w;
    w.action      = act;
    w.tick_clocks = ticks;
    w.reg_select  = sel;
    w.write_data  = data;
    return w;
  endfunction

  // Draw a random word; tick_pct sets the share of ticks
  function automatic item_t random_word(int tick_pct, bit allow_disable);
    item_t w;
    int    pick;
    int    read_top;
    w.tick_clocks = 8'($urandom_range(0, 255));
    w.reg_select  = 2'($urandom_range(0, 3));
    w.write_data  = 8'($urandom_range(0, 255));
    read_top = tick_pct + (97 - tick_pct) / 2;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      w.action = ACT_TICK;
      if ($urandom_range(0, 3) != 0) w.tick_clocks = 8'($urandom_range(150, 255));
    end else if (pick < read_top) begin
      w.action = ACT_READ;
    end else if (pick < 97) begin
      w.action = ACT_WRITE;
      case (w.reg_select)
        REG_CONTROL:
          if (!allow_disable || $urandom_range(0, 4) != 0) w.write_data[CTRL_ENABLE] = 1'b1;
        REG_LINE:    if ($urandom_range(0, 2) != 0) w.write_data = 8'($urandom_range(138, 158));
        REG_COMPARE:
          if ($urandom_range(0, 1) != 0) w.write_data = shadow_line + 8'($urandom_range(0, 3));
        default: ;
      endcase
    end else begin
      w.action = ACT_UNUSED;
    end
    return w;
  endfunction

  // Check each accepted result against the oldest expectation
  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_results_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual read_data %0h", $time,
                 out_read_data);
        error_count++;
      end else begin
        e = lcd_results_due.pop_front();
        check_field("read_data", e.read_data, out_read_data);
        check_field("stat_irq", {7'd0, e.stat_irq}, {7'd0, out_stat_irq});
        check_field("vblank_irq", {7'd0, e.vblank_irq}, {7'd0, out_vblank_irq});
        check_field("hblank_entered", {7'd0, e.hblank_entered}, {7'd0, out_hblank_entered});
        check_field("line_done", {7'd0, e.line_done}, {7'd0, out_line_done});
        check_field("line_number", e.line_number, out_line_number);
      end
    end
  end

  // Result sink: random stalls, plus a long hold when requested
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      n = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_reset_values();
    send_word(make_word(ACT_READ, 8'h00, REG_CONTROL, 8'h00));
    send_word(make_word(ACT_READ, 8'hFF, REG_STATUS, 8'hFF));
    send_word(make_word(ACT_READ, 8'h00, REG_LINE, 8'hFF));
    send_word(make_word(ACT_READ, 8'hFF, REG_COMPARE, 8'h00));
  endtask

  // Enable every status interrupt and finish the first and the last visible line
  task automatic test_line_ends();
    send_word(make_word(ACT_WRITE, 8'h00, REG_STATUS, 8'hFF));
    send_word(make_word(ACT_TICK, 8'h00, REG_STATUS, 8'h00));
    send_word(make_word(ACT_TICK, 8'hFF, REG_CONTROL, 8'hFF));
    send_word(make_word(ACT_TICK, 8'hFF, REG_LINE, 8'h00));
    send_word(make_word(ACT_WRITE, 8'h00, REG_LINE, 8'd143));
    send_word(make_word(ACT_TICK, 8'hFF, REG_COMPARE, 8'h00));
    send_word(make_word(ACT_TICK, 8'hFF, REG_STATUS, 8'hFF));
  endtask

  // Vblank request at line 144, wrap after 153 and after an out-of-range line
  task automatic test_vblank_and_wrap();
    send_word(make_word(ACT_WRITE, 8'h00, REG_LINE, VBLANK_LINE));
    send_word(make_word(ACT_TICK, 8'hFF, REG_CONTROL, 8'h00));
    send_word(make_word(ACT_TICK, 8'hFF, REG_LINE, 8'h00));
    send_word(make_word(ACT_WRITE, 8'h00, REG_LINE, LAST_LINE));
    send_word(make_word(ACT_TICK, 8'hFF, REG_COMPARE, 8'hFF));
    send_word(make_word(ACT_TICK, 8'hFF, REG_STATUS, 8'h00));
    send_word(make_word(ACT_WRITE, 8'h00, REG_LINE, 8'hFF));
    send_word(make_word(ACT_TICK, 8'hFF, REG_LINE, 8'h00));
    send_word(make_word(ACT_TICK, 8'hFF, REG_CONTROL, 8'h00));
  endtask

  // Disabled display forces vblank and clears line and clock
  task automatic test_lcd_disable();
    send_word(make_word(ACT_WRITE, 8'h00, REG_CONTROL, 8'h00));
    send_word(make_word(ACT_TICK, 8'hFF, REG_CONTROL, 8'h00));
    send_word(make_word(ACT_READ, 8'h00, REG_STATUS, 8'h00));
    send_word(make_word(ACT_WRITE, 8'h00, REG_CONTROL, CONTROL_RESET));
  endtask

  task automatic test_unused_action();
    send_word(make_word(ACT_UNUSED, 8'hFF, REG_COMPARE, 8'hFF));
  endtask

  // Hold the sink off for a long stretch while words keep coming
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_request = 80;
    repeat (30) send_word(random_word(60, 1'b0));
    idle_on = 1'b1;
  endtask

  // Mixed bus traffic with random gaps, then a stretch without gaps
  task automatic test_random_traffic();
    repeat (450) send_word(random_word(55, 1'b1));
    idle_on = 1'b0;
    repeat (150) send_word(random_word(55, 1'b1));
    idle_on = 1'b1;
  endtask

  // Mostly large ticks so that whole frames go by
  task automatic test_frame_sweep();
    repeat (700) send_word(random_word(90, 1'b0));
  endtask

  task automatic wait_for_drain();
    int n;
    n = 0;
    while (lcd_results_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (lcd_results_due.size() != 0) begin
      $display("%0t: results outstanding: expected 0, actual %0d", $time,
               lcd_results_due.size());
      error_count++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    shadow_control = CONTROL_RESET;
    shadow_status  = STATUS_RESET;
    shadow_line    = '0;
    shadow_compare = '0;
    shadow_clock   = '0;
    // Hold reset, then release it on a falling clock edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_line_ends();
    test_vblank_and_wrap();
    test_lcd_disable();
    test_unused_action();
    test_backpressure();
    test_random_traffic();
    test_frame_sweep();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_drain();

    $display("Sent %0d ticks, %0d reads, %0d writes, %0d unused words", ticks_sent,
             reads_sent, writes_sent, unused_sent);
    $display("Drew %0d lines, %0d vblank requests, %0d wraps, %0d input stall cycles",
             lines_drawn, vblanks_seen, wraps_seen, input_stall_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ltc_pkg.sv
rtl/ltc_in_reg.sv
rtl/ltc_core.sv
rtl/ltc_out_reg.sv
rtl/lcd_line_timing_controller_top.sv
bench/lcd_line_timing_controller_top_tb.sv
